### design/spq_pkg.sv
// Shared types, op codes and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEFAULT = 1024;
    localparam int DATA_W           = 32;
    localparam int POS_W            = 11;
    localparam int MODE_W           = 2;
    localparam int IN_TDATA_W       = 64;
    localparam int OUT_TDATA_W      = 80;

    localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQUEUE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH  = 2'd2;

    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] dp_op_t;

    localparam dp_op_t OP_NONE      = 4'd0;
    localparam dp_op_t OP_LOAD      = 4'd1;
    localparam dp_op_t OP_OVF       = 4'd2;
    localparam dp_op_t OP_EMPTY     = 4'd3;
    localparam dp_op_t OP_INS_START = 4'd4;
    localparam dp_op_t OP_INS_SHIFT = 4'd5;
    localparam dp_op_t OP_INS_PUT   = 4'd6;
    localparam dp_op_t OP_RD_FRONT  = 4'd7;
    localparam dp_op_t OP_DEQ_TAKE  = 4'd8;
    localparam dp_op_t OP_SRCH_STEP = 4'd9;
    localparam dp_op_t OP_FOUND     = 4'd10;
    localparam dp_op_t OP_OUT_LOAD  = 4'd11;

    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] item;
    } entry_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              count_zero;
        logic              full;
        logic              shift_ok;
        logic              hole_one;
        logic              match;
        logic              last;
        logic              out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### design/spq_ctrl.sv
// Sequencing state machine for the sorted priority queue.
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_op_t          op
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SHIFT    = 3'd2;
    localparam logic [2:0] S_PUT      = 3'd3;
    localparam logic [2:0] S_DEQ      = 3'd4;
    localparam logic [2:0] S_SRCH     = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (status.mode)
                    MODE_INSERT: begin
                        if (status.full) begin
                            op         = OP_OVF;
                            state_next = S_RESP;
                        end else begin
                            op         = OP_INS_START;
                            state_next = status.count_zero ? S_PUT : S_SHIFT;
                        end
                    end
                    MODE_DEQUEUE: begin
                        if (status.count_zero) begin
                            op         = OP_EMPTY;
                            state_next = S_RESP;
                        end else begin
                            op         = OP_RD_FRONT;
                            state_next = S_DEQ;
                        end
                    end
                    MODE_SEARCH: begin
                        if (status.count_zero) begin
                            state_next = S_RESP;
                        end else begin
                            op         = OP_RD_FRONT;
                            state_next = S_SRCH;
                        end
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SHIFT: begin
                op         = OP_INS_SHIFT;
                state_next = (status.shift_ok && !status.hole_one) ? S_SHIFT : S_PUT;
            end
            S_PUT: begin
                op         = OP_INS_PUT;
                state_next = S_RESP;
            end
            S_DEQ: begin
                op         = OP_DEQ_TAKE;
                state_next = S_RESP;
            end
            S_SRCH: begin
                if (status.match) begin
                    op         = OP_FOUND;
                    state_next = S_RESP;
                end else if (status.last) begin
                    state_next = S_RESP;
                end else begin
                    op = OP_SRCH_STEP;
                end
            end
            S_RESP: begin
                if (status.out_free) begin
                    op         = OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_walk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT || state_reg == S_SRCH || state_reg == S_DEQ)
            |-> !status.count_zero)
        else $error("queue walk started on an empty store");

    a_resp_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && !status.out_free) |=> (state_reg == S_RESP))
        else $error("result left before the output register freed up");

endmodule

`default_nettype wire

### design/spq_dp.sv
// Entry store, pointers, request and result registers of the sorted priority queue.
`default_nettype none

module spq_dp
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire dp_op_t                 op,
    input  wire logic [IN_TDATA_W-1:0]  in_data,
    input  wire logic [MODE_W-1:0]      in_mode,
    output dp_status_t                  status,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] CAP_S    = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C    = CNT_W'(2);

    entry_t mem [CAPACITY];

    logic [IDX_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         cur_reg, cur_next;
    entry_t                   rd_data_reg;
    logic [MODE_W-1:0]        req_mode_reg;
    logic signed [DATA_W-1:0] req_item_reg;
    logic signed [DATA_W-1:0] req_prio_reg;
    logic [POS_W-1:0]         res_pos_reg;
    logic signed [DATA_W-1:0] res_item_reg;
    logic signed [DATA_W-1:0] res_prio_reg;
    logic                     res_empty_reg;
    logic                     res_found_reg;
    logic                     res_ovf_reg;
    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;

    logic                     rd_en, wr_en;
    logic [CNT_W-1:0]         rd_lidx, wr_lidx;
    logic [IDX_W-1:0]         rd_addr, wr_addr;
    entry_t                   wr_data;
    logic                     shift_ok;
    logic [CNT_W-1:0]         pos_full;
    logic [CNT_W+POS_W-1:0]   pos_ext;

    function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] lidx);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(lidx);
        if (sum >= CAP_S) begin
            sum = sum - CAP_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    // front slot yields only to a strictly higher priority, the rest on ties too
    assign shift_ok = (cur_reg == ONE_C) ? (rd_data_reg.prio < req_prio_reg)
                                         : (rd_data_reg.prio <= req_prio_reg);
    assign pos_full = cur_reg + ONE_C;
    assign pos_ext  = {{POS_W{1'b0}}, pos_full};

    always_comb begin
        rd_en      = 1'b0;
        rd_lidx    = '0;
        wr_en      = 1'b0;
        wr_lidx    = cur_reg;
        wr_data    = rd_data_reg;
        head_next  = head_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        case (op)
            OP_INS_START: begin
                cur_next = count_reg;
                rd_en    = (count_reg != '0);
                rd_lidx  = count_reg - ONE_C;
            end
            OP_INS_SHIFT: begin
                if (shift_ok) begin
                    wr_en    = 1'b1;
                    cur_next = cur_reg - ONE_C;
                    rd_en    = (cur_reg != ONE_C);
                    rd_lidx  = cur_reg - TWO_C;
                end
            end
            OP_INS_PUT: begin
                wr_en      = 1'b1;
                wr_data    = '{prio: req_prio_reg, item: req_item_reg};
                count_next = count_reg + ONE_C;
            end
            OP_RD_FRONT: begin
                cur_next = '0;
                rd_en    = 1'b1;
            end
            OP_SRCH_STEP: begin
                cur_next = cur_reg + ONE_C;
                rd_en    = 1'b1;
                rd_lidx  = cur_reg + ONE_C;
            end
            OP_DEQ_TAKE: begin
                head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                count_next = count_reg - ONE_C;
            end
            default: begin
            end
        endcase
    end

    assign rd_addr = to_phys(head_reg, rd_lidx);
    assign wr_addr = to_phys(head_reg, wr_lidx);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        case (op)
            OP_LOAD: begin
                req_mode_reg  <= in_mode;
                req_item_reg  <= in_data[DATA_W-1:0];
                req_prio_reg  <= in_data[2*DATA_W-1:DATA_W];
                res_pos_reg   <= '0;
                res_item_reg  <= '0;
                res_prio_reg  <= '0;
                res_empty_reg <= 1'b0;
                res_found_reg <= 1'b0;
                res_ovf_reg   <= 1'b0;
            end
            OP_OVF:      res_ovf_reg   <= 1'b1;
            OP_EMPTY:    res_empty_reg <= 1'b1;
            OP_FOUND:    res_found_reg <= 1'b1;
            OP_INS_PUT:  res_pos_reg   <= pos_ext[POS_W-1:0];
            OP_DEQ_TAKE: begin
                res_item_reg <= rd_data_reg.item;
                res_prio_reg <= rd_data_reg.prio;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (op == OP_OUT_LOAD) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == OP_OUT_LOAD) begin
            out_data_reg <= {2'b00, res_ovf_reg, res_found_reg, res_empty_reg,
                             res_prio_reg, res_item_reg, res_pos_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.mode       = req_mode_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.full       = (count_reg == CAP_C);
    assign status.shift_ok   = shift_ok;
    assign status.hole_one   = (cur_reg == ONE_C);
    assign status.match      = (rd_data_reg.item == req_item_reg);
    assign status.last       = (cur_reg == count_reg - ONE_C);
    assign status.out_free   = !out_valid_reg || m_tready;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CAP_C) && (head_reg <= LAST_IDX))
        else $error("count or head out of range");

    a_put_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_INS_PUT) |=> (count_reg == $past(count_reg) + ONE_C))
        else $error("insert did not grow the queue");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_OUT_LOAD) |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while held");

    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ($countones(out_data_reg[OUT_TDATA_W-3:OUT_TDATA_W-5]) <= 1))
        else $error("more than one outcome flag in a result");

endmodule

`default_nettype wire

### design/sorted_priority_queue_core.sv
// Top level: sorted-list priority queue with stream ports.
// One item in flight: search scans from the front up to a match, insert moves entries back
// one at a time before placing the new one; the next beat is accepted in the cycle after
// the result loads into the output register.
// The entry memory (one read, one write per cycle) sets the one-entry-per-cycle walk.
// Reset clears count, head and handshake state; entry memory contents are not cleared.
`default_nettype none

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // item_value[31:0], priority_req[63:32]
    input  wire logic [MODE_W-1:0]      s_tuser,   // mode[1:0]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // insert_position[10:0], front_item[42:11],
                                                   // front_priority[74:43], was_empty[75],
                                                   // found[76], overflow[77], zero[79:78]
);

    dp_status_t status;
    dp_op_t     op;

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .in_data  (s_tdata),
        .in_mode  (s_tuser),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
